/* rtl/sorted_list_table_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list table
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted list table package
// Operation and status codes and the command and result transfer structs.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Operation requested by a command.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } mode_e;

  // Completion status of a command.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Command payload.
  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] value;
  } req_t;

  // Result payload.
  typedef struct packed {
    status_e    status;
    logic [4:0] position;
    logic [4:0] count;
  } rsp_t;

endpackage

/* rtl/sorted_list_table.sv */
// From the accepting edge, clear, a full-table insert, or a search or delete on an empty table
// go straight to the finish state; otherwise each stored entry visited passes through a read
// state and a compare state, and an insert ends with a write state before the finish state.
// Busy drops in the strobe cycle, so the next command can be taken at the edge that ends it.
// The result strobe done_o lasts one cycle and cannot be stalled.
// Reset empties the table by clearing the fill count; storage is not cleared.
// ----------------------------------------------------------------------------
// Sorted list table
// Ascending table of signed values with insert, search, delete and clear,
// run by a small sequencer around one comparator, one write port and one read port.
// ----------------------------------------------------------------------------
module sorted_list_table #(
  parameter int DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  slt_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output slt_pkg::rsp_t rsp_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_INS  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  slt_pkg::mode_e         op_q, op_d;
  logic signed [31:0]     val_q, val_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          fill_q, fill_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic                   found_q, found_d;
  slt_pkg::status_e       status_q, status_d;
  logic                   done_q;
  slt_pkg::rsp_t          rsp_q;

  logic signed [31:0]     mem_q [DEPTH];
  logic signed [31:0]     rdata_q;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic signed [31:0]     wdata;
  logic [CW-1:0]          rd_idx;
  logic [CW-1:0]          idx_inc;
  logic [CW-1:0]          idx_inc2;
  logic [CW-1:0]          idx_dec;
  logic                   lt;
  logic                   eq;
  logic [CW+4:0]          pos_ext;
  logic [CW+4:0]          fill_ext;

  assign idx_inc  = idx_q + CW'(1);
  assign idx_inc2 = idx_q + CW'(2);
  assign idx_dec  = idx_q - CW'(1);

  // Shared comparator between the fetched entry and the operand.
  assign lt = rdata_q < val_q;
  assign eq = rdata_q == val_q;

  // Read address: insert walks down, a delete in its shift phase reads ahead.
  always_comb begin
    if (found_q && (op_q == slt_pkg::OP_DELETE)) begin
      rd_idx = idx_inc;
    end else if (op_q == slt_pkg::OP_INSERT) begin
      rd_idx = idx_dec;
    end else begin
      rd_idx = idx_q;
    end
  end

  // Entry storage with a registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[rd_idx[AW-1:0]];
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    val_d    = val_q;
    idx_d    = idx_q;
    fill_d   = fill_q;
    pos_d    = pos_q;
    found_d  = found_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = idx_q[AW-1:0];
    wdata    = rdata_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = req_i.mode;
          val_d    = req_i.value;
          found_d  = 1'b0;
          pos_d    = '0;
          idx_d    = '0;
          status_d = slt_pkg::ST_OK;
          unique case (req_i.mode) inside
            slt_pkg::OP_INSERT: begin
              if (fill_q == CW'(DEPTH)) begin
                status_d = slt_pkg::ST_FULL;
                state_d  = S_FIN;
              end else begin
                idx_d   = fill_q;
                state_d = (fill_q == '0) ? S_INS : S_RD;
              end
            end
            slt_pkg::OP_SEARCH, slt_pkg::OP_DELETE: begin
              if (fill_q == '0) begin
                status_d = slt_pkg::ST_NOT_FOUND;
                state_d  = S_FIN;
              end else begin
                state_d = S_RD;
              end
            end
            default: begin
              fill_d  = '0;
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        unique case (op_q)
          slt_pkg::OP_INSERT: begin
            // Shift entries not smaller than the operand up by one slot.
            if (!lt) begin
              we    = 1'b1;
              idx_d = idx_dec;
              state_d = (idx_q == CW'(1)) ? S_INS : S_RD;
            end else begin
              state_d = S_INS;
            end
          end
          slt_pkg::OP_SEARCH: begin
            if (lt || eq) begin
              found_d = found_q || eq;
              idx_d   = idx_inc;
              if (idx_inc == fill_q) begin
                pos_d    = idx_inc;
                status_d = found_d ? slt_pkg::ST_OK : slt_pkg::ST_NOT_FOUND;
                state_d  = S_FIN;
              end else begin
                state_d = S_RD;
              end
            end else begin
              pos_d    = idx_q;
              status_d = found_q ? slt_pkg::ST_OK : slt_pkg::ST_NOT_FOUND;
              state_d  = S_FIN;
            end
          end
          slt_pkg::OP_DELETE: begin
            if (found_q) begin
              // Close the gap: move the next entry down one slot.
              we    = 1'b1;
              idx_d = idx_inc;
              if (idx_inc2 == fill_q) begin
                fill_d  = fill_q - CW'(1);
                state_d = S_FIN;
              end else begin
                state_d = S_RD;
              end
            end else if (eq) begin
              found_d = 1'b1;
              if (idx_inc == fill_q) begin
                fill_d  = fill_q - CW'(1);
                state_d = S_FIN;
              end else begin
                state_d = S_RD;
              end
            end else begin
              idx_d = idx_inc;
              if (idx_inc == fill_q) begin
                status_d = slt_pkg::ST_NOT_FOUND;
                state_d  = S_FIN;
              end else begin
                state_d = S_RD;
              end
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_INS: begin
        we      = 1'b1;
        wdata   = val_q;
        fill_d  = fill_q + CW'(1);
        state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      found_q <= 1'b0;
      op_q    <= slt_pkg::OP_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      found_q <= found_d;
      op_q    <= op_d;
      done_q  <= (state_q == S_FIN);
    end
  end

  // Operand, index and result payload registers.
  assign pos_ext  = {5'b0, pos_q};
  assign fill_ext = {5'b0, fill_q};

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    if (state_q == S_FIN) begin
      rsp_q.status   <= status_q;
      rsp_q.position <= (op_q == slt_pkg::OP_SEARCH) ? pos_ext[4:0] : 5'd0;
      rsp_q.count    <= fill_ext[4:0];
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* rtl/slt_checker.sv */
// ----------------------------------------------------------------------------
// Sorted list table port checker
// Watches the command and result ports of the table over time.
// ----------------------------------------------------------------------------
`include "sorted_list_table_macros.svh"

module slt_checker #(
  parameter int DEPTH = 16
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input slt_pkg::rsp_t rsp_o
);

  logic accept;
  logic [31:0] depth_w;

  assign accept  = start && !busy;
  assign depth_w = 32'(DEPTH);

  // An accepted command always makes the block busy in the following cycle.
  `SLT_ASSERT_NEXT(a_accept_busy, accept, busy, "command accepted but block not busy")
  // A result is shown only once the sequencer is back at rest.
  `SLT_ASSERT_NOW(a_done_idle, done_o, !busy, "result strobe while busy")
  // One result per command: strobes never come back to back.
  `SLT_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe repeated")
  // A dropped insert reports the table at capacity.
  `SLT_ASSERT_NOW(a_full_count, done_o && (rsp_o.status == slt_pkg::ST_FULL),
    rsp_o.count == depth_w[4:0], "full status with count below capacity")

endmodule

bind sorted_list_table slt_checker #(.DEPTH(DEPTH)) u_slt_checker (.*);

/* tb/sorted_list_table_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted list table result checker
// Watches the command and result channels, keeps its own ordered table to
// work out each expected result, and compares every result field by field.
// ----------------------------------------------------------------------------
module sorted_list_table_check #(
  parameter int DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  slt_pkg::req_t req_i,
  input  logic          done_i,
  input  slt_pkg::rsp_t rsp_i,
  output int            fail_count_o,
  output int            pending_o
);

  // Shadow copy of the table: ascending values in slots 0 to held_n-1.
  logic signed [31:0] held_vals [DEPTH];
  int                 held_n;

  // Results still owed by the block, oldest first.
  slt_pkg::rsp_t expected_rsps [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    held_n       = 0;
  end

  // Apply one command to the shadow table and return the result it gives.
  function automatic slt_pkg::rsp_t apply_table_op(slt_pkg::req_t cmd);
    slt_pkg::rsp_t      rsp;
    logic signed [31:0] v;
    int                 idx;
    int                 pos;
    bit                 found;
    v     = cmd.value;
    idx   = 0;
    pos   = 0;
    found = 1'b0;
    rsp.status = slt_pkg::ST_OK;
    case (cmd.mode)
      slt_pkg::OP_INSERT: begin
        if (held_n >= DEPTH) begin
          rsp.status = slt_pkg::ST_FULL;
        end else begin
          // Equal values go ahead of earlier equal ones: stop at the first not-smaller entry.
          while (idx < held_n && held_vals[idx] < v) idx++;
          for (int j = held_n; j > idx; j--) held_vals[j] = held_vals[j-1];
          held_vals[idx] = v;
          held_n++;
        end
      end
      slt_pkg::OP_SEARCH: begin
        while (idx < held_n && held_vals[idx] <= v) begin
          if (held_vals[idx] == v) found = 1'b1;
          idx++;
        end
        pos        = idx;
        rsp.status = found ? slt_pkg::ST_OK : slt_pkg::ST_NOT_FOUND;
      end
      slt_pkg::OP_DELETE: begin
        while (idx < held_n && held_vals[idx] != v) idx++;
        if (idx >= held_n) begin
          rsp.status = slt_pkg::ST_NOT_FOUND;
        end else begin
          for (int j = idx; j < held_n - 1; j++) held_vals[j] = held_vals[j+1];
          held_n--;
        end
      end
      slt_pkg::OP_CLEAR: begin
        held_n = 0;
      end
    endcase
    rsp.position = pos[4:0];
    rsp.count    = held_n[4:0];
    return rsp;
  endfunction

  // Compare each result transfer first, then record any accepted command.
  always @(posedge clk_i or negedge rst_ni) begin
    slt_pkg::rsp_t exp_rsp;
    if (!rst_ni) begin
      held_n = 0;
      expected_rsps.delete();
    end else begin
      if (done_i) begin
        if (expected_rsps.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count_o++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp_i.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_i.status);
            fail_count_o++;
          end
          if (rsp_i.position !== exp_rsp.position) begin
            $error("position: expected %0d, actual %0d", exp_rsp.position,
                   rsp_i.position);
            fail_count_o++;
          end
          if (rsp_i.count !== exp_rsp.count) begin
            $error("count: expected %0d, actual %0d", exp_rsp.count, rsp_i.count);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) expected_rsps.push_back(apply_table_op(req_i));
    end
    pending_o = expected_rsps.size();
  end

endmodule

/* tb/sorted_list_table_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted list table testbench
// Drives directed and random insert, search, delete and clear commands with
// random sender gaps; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module sorted_list_table_test;

  localparam int DEPTH     = 16;
  localparam int N_RANDOM  = 1100;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  slt_pkg::req_t  req_i = '0;
  logic           busy;
  logic           done_o;
  slt_pkg::rsp_t  rsp_o;
  int             fail_count;
  int             pending;

  // Values inserted lately, so that searches and deletes often hit.
  logic signed [31:0] recent_vals [8];
  bit                 idle_on;

  always #1 clk_i = ~clk_i;

  sorted_list_table #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  sorted_list_table_check #(.DEPTH(DEPTH)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .done_i       (done_o),
    .rsp_i        (rsp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offer one command and return at the edge where its transfer happens.
  // start stays high afterwards so that back-to-back commands need no dip.
  task automatic issue(slt_pkg::mode_e m, logic signed [31:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    req_i.mode  <= m;
    req_i.value <= v;
    do @(posedge clk_i); while (busy);
  endtask

  // Mix of small values with many duplicates, recent values, extremes and
  // fully random words.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $signed($urandom_range(0, 16)) - 8;
      5, 6:          v = recent_vals[$urandom_range(0, 7)];
      7: begin
        case ($urandom_range(0, 3))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = VAL_MIN + 1;
          default: v = VAL_MAX - 1;
        endcase
      end
      default:       v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    int             ins_w;
    int             r;
    slt_pkg::mode_e m;
    logic signed [31:0] v;

    foreach (recent_vals[i]) recent_vals[i] = '0;
    idle_on = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, extremes, duplicates, misses, full table.
    issue(slt_pkg::OP_SEARCH, 0);
    issue(slt_pkg::OP_DELETE, 5);
    issue(slt_pkg::OP_CLEAR, 32'hDEAD_BEEF);
    issue(slt_pkg::OP_INSERT, VAL_MAX);
    issue(slt_pkg::OP_INSERT, VAL_MIN);
    issue(slt_pkg::OP_INSERT, 0);
    issue(slt_pkg::OP_INSERT, 0);
    issue(slt_pkg::OP_INSERT, -1);
    issue(slt_pkg::OP_SEARCH, 0);
    issue(slt_pkg::OP_SEARCH, 1);
    issue(slt_pkg::OP_SEARCH, VAL_MAX);
    issue(slt_pkg::OP_SEARCH, VAL_MIN);
    issue(slt_pkg::OP_DELETE, 0);
    issue(slt_pkg::OP_DELETE, 7);
    for (int i = 0; i < 12; i++) issue(slt_pkg::OP_INSERT, i * 1000 - 5000);
    issue(slt_pkg::OP_INSERT, 3);
    issue(slt_pkg::OP_SEARCH, VAL_MAX);
    issue(slt_pkg::OP_DELETE, VAL_MAX);
    issue(slt_pkg::OP_CLEAR, -1);

    // Random part in blocks that lean toward filling or draining the table.
    ins_w = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) begin
        ins_w   = $urandom_range(25, 70);
        idle_on = ($urandom_range(0, 2) != 0);
      end
      if (n >= N_RANDOM - QUIET_TAIL) idle_on = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 2)               m = slt_pkg::OP_CLEAR;
      else if (r < ins_w)      m = slt_pkg::OP_INSERT;
      else if (r < ins_w + 20) m = slt_pkg::OP_SEARCH;
      else                     m = slt_pkg::OP_DELETE;
      v = pick_value();
      if (m == slt_pkg::OP_INSERT) recent_vals[$urandom_range(0, 7)] = v;
      issue(m, v);
    end
    start <= 1'b0;

    // Wait for every owed result, then let the block settle.
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
